// File: rtl/assert_macros.svh
// Assertion macros included by the RTL of the telemetry frame decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle, with reset masking.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that an antecedent implies a consequent in the next cycle, with reset masking.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/stfd_pkg.sv
// Opcodes, frame kinds and the result type of the servo telemetry frame decoder.
`default_nettype none

package stfd_pkg;

	// Frame opcodes carried in the oldest window byte
	localparam logic [7:0] OP_STATUS  = 8'h80;
	localparam logic [7:0] OP_VOLTAGE = 8'hE1;
	localparam logic [7:0] OP_CURRENT = 8'hE2;
	localparam logic [7:0] OP_SPEED   = 8'hE4;
	localparam logic [7:0] OP_POS_HI  = 8'hE8;
	localparam logic [7:0] OP_POS_LO  = 8'hE9;

	// Status bits that force a stop
	localparam logic [7:0] STAT_OVERCURRENT = 8'h01 << 1;
	localparam logic [7:0] STAT_OVERLOAD    = 8'h01 << 6;

	// Fill for the low position half when the high half is written
	localparam logic [15:0] POS_LOW_FILL = 16'hFFFF;

	// Frame kinds reported with each result
	localparam logic [2:0] KIND_NONE    = 3'd0;
	localparam logic [2:0] KIND_STATUS  = 3'd1;
	localparam logic [2:0] KIND_VOLTAGE = 3'd2;
	localparam logic [2:0] KIND_CURRENT = 3'd3;
	localparam logic [2:0] KIND_SPEED   = 3'd4;
	localparam logic [2:0] KIND_POS_HI  = 3'd5;
	localparam logic [2:0] KIND_POS_LO  = 3'd6;

	// One result item
	typedef struct packed {
		logic [2:0]         frame_kind;
		logic [7:0]         fault_status;
		logic               stop_fault;
		logic signed [15:0] bus_voltage;
		logic signed [15:0] phase_current;
		logic signed [15:0] motor_speed;
		logic signed [31:0] position_count;
		logic               link_alive;
	} res_t;

endpackage

`default_nettype wire

// File: rtl/servo_telemetry_frame_decoder.sv
// Servo telemetry frame decoder: byte window, frame check and telemetry registers.
//
// Usage:
//   Input channel (in_valid, in_stall, rx_byte) takes one received link byte per
//   transfer. The byte joins the three before it to form a four-byte frame:
//   opcode, data high, data low, checksum (8-bit sum of the first three).
//   Output channel (out_valid, out_stall, result fields) delivers one result per
//   input byte: the kind of frame this byte completed, the telemetry registers as
//   they stand after it, and link_alive for a valid voltage frame.
//   Each result is registered in the result register, or in the skid if stalled.
//   Throughput: one byte per cycle while in_stall is low; the frame check and
//   register update are a single combinational pass, byte window to result register.
//   Stall: a one-entry skid register behind the result register takes one more
//   result while the receiver stalls; in_stall rises only while the skid is full.
//   Reset (arst_n low, asynchronous): the byte window and all telemetry registers
//   clear to zero and no result is pending.
`default_nettype none
`include "assert_macros.svh"

module servo_telemetry_frame_decoder (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         rx_byte,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              frame_kind,
	output logic [7:0]              fault_status,
	output logic                    stop_fault,
	output logic signed [15:0]      bus_voltage,
	output logic signed [15:0]      phase_current,
	output logic signed [15:0]      motor_speed,
	output logic signed [31:0]      position_count,
	output logic                    link_alive
);

	logic [7:0]  win_op_q, win_hi_q, win_lo_q;
	logic [7:0]  fault_q;
	logic        stop_q;
	logic [15:0] voltage_q, current_q, speed_q;
	logic [31:0] position_q;

	logic [7:0]  fault_d;
	logic        stop_d;
	logic [15:0] voltage_d, current_d, speed_d;
	logic [31:0] position_d;
	logic [2:0]  kind_d;
	logic        alive_d;
	logic [7:0]  sum;
	logic [15:0] word;

	stfd_pkg::res_t res_d, out_q, skid_q;
	logic           out_valid_q, skid_valid_q;
	logic           in_xfer, out_xfer, out_free;

	// Handshake
	assign in_stall = skid_valid_q;
	assign in_xfer  = in_valid & ~skid_valid_q;
	assign out_xfer = out_valid_q & ~out_stall;
	assign out_free = out_xfer | ~out_valid_q;

	// Check the frame and work out the next telemetry values
	assign sum  = win_op_q + win_hi_q + win_lo_q;
	assign word = {win_hi_q, win_lo_q};

	always_comb begin
		fault_d    = fault_q;
		stop_d     = stop_q;
		voltage_d  = voltage_q;
		current_d  = current_q;
		speed_d    = speed_q;
		position_d = position_q;
		kind_d     = stfd_pkg::KIND_NONE;
		alive_d    = 1'b0;
		if (sum == rx_byte) begin
			case (win_op_q)
				stfd_pkg::OP_STATUS: begin
					fault_d = win_lo_q;
					stop_d  = (win_lo_q & (stfd_pkg::STAT_OVERCURRENT |
						stfd_pkg::STAT_OVERLOAD)) != 8'h00;
					kind_d  = stfd_pkg::KIND_STATUS;
				end
				stfd_pkg::OP_VOLTAGE: begin
					voltage_d = word;
					alive_d   = 1'b1;
					kind_d    = stfd_pkg::KIND_VOLTAGE;
				end
				stfd_pkg::OP_CURRENT: begin
					current_d = word;
					kind_d    = stfd_pkg::KIND_CURRENT;
				end
				stfd_pkg::OP_SPEED: begin
					speed_d = word;
					kind_d  = stfd_pkg::KIND_SPEED;
				end
				stfd_pkg::OP_POS_HI: begin
					position_d = {word, stfd_pkg::POS_LOW_FILL};
					kind_d     = stfd_pkg::KIND_POS_HI;
				end
				stfd_pkg::OP_POS_LO: begin
					position_d = {position_q[31:16], word};
					kind_d     = stfd_pkg::KIND_POS_LO;
				end
				default: begin
					kind_d = stfd_pkg::KIND_NONE;
				end
			endcase
		end
	end

	// Assemble the result item
	always_comb begin
		res_d.frame_kind     = kind_d;
		res_d.fault_status   = fault_d;
		res_d.stop_fault     = stop_d;
		res_d.bus_voltage    = $signed(voltage_d);
		res_d.phase_current  = $signed(current_d);
		res_d.motor_speed    = $signed(speed_d);
		res_d.position_count = $signed(position_d);
		res_d.link_alive     = alive_d;
	end

	// Advance the byte window and commit telemetry on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_op_q   <= 8'h00;
			win_hi_q   <= 8'h00;
			win_lo_q   <= 8'h00;
			fault_q    <= 8'h00;
			stop_q     <= 1'b0;
			voltage_q  <= 16'h0000;
			current_q  <= 16'h0000;
			speed_q    <= 16'h0000;
			position_q <= 32'h0000_0000;
		end else if (in_xfer) begin
			win_op_q   <= win_hi_q;
			win_hi_q   <= win_lo_q;
			win_lo_q   <= rx_byte;
			fault_q    <= fault_d;
			stop_q     <= stop_d;
			voltage_q  <= voltage_d;
			current_q  <= current_d;
			speed_q    <= speed_d;
			position_q <= position_d;
		end
	end

	// Track result and skid occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q | in_xfer;
			skid_valid_q <= 1'b0;
		end else if (in_xfer) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Load result payload: drain the skid first, else take the new result; park it in the skid while held
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_xfer) begin
				out_q <= res_d;
			end
		end else if (in_xfer) begin
			skid_q <= res_d;
		end
	end

	// Drive the output ports
	assign out_valid      = out_valid_q;
	assign frame_kind     = out_q.frame_kind;
	assign fault_status   = out_q.fault_status;
	assign stop_fault     = out_q.stop_fault;
	assign bus_voltage    = out_q.bus_voltage;
	assign phase_current  = out_q.phase_current;
	assign motor_speed    = out_q.motor_speed;
	assign position_count = out_q.position_count;
	assign link_alive     = out_q.link_alive;

	// Assertions
	`ASSERT_SAME(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q,
		"skid full with empty output")
	`ASSERT_NEXT(a_stall_fills_skid, clk, arst_n, out_valid_q && out_stall && in_xfer,
		skid_valid_q, "stalled transfer lost")
	`ASSERT_SAME(a_alive_is_voltage, clk, arst_n, out_valid_q,
		link_alive == (frame_kind == stfd_pkg::KIND_VOLTAGE),
		"link_alive out of step with frame kind")

endmodule

`default_nettype wire
